[hdl/positional_pid_with_integral_separation_assert.svh]
// Assertion macros shared by the PID controller modules.
`ifndef POSITIONAL_PID_WITH_INTEGRAL_SEPARATION_ASSERT_SVH
`define POSITIONAL_PID_WITH_INTEGRAL_SEPARATION_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PPIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ppis_pkg.sv]
// Shared types and constants for the positional PID controller.
package ppis_pkg;

  localparam int GainW   = 16;
  localparam int LimitW  = 24;
  localparam int IntegW  = 25;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INT_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DRIVE_MAX = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DRIVE_MIN = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SEP_THR   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SEP_EN    = 3'd7;

  localparam logic [GainW-1:0]  GainPReset    = 16'd256;
  localparam logic [LimitW-1:0] IntLimitReset = 24'd100;

  typedef struct packed {
    logic signed [GainW-1:0] p;
    logic signed [GainW-1:0] i;
    logic signed [GainW-1:0] d;
  } gains_t;

endpackage

[hdl/ppis_if.sv]
// Channel interfaces: sample input, drive output and register write port.
interface ppis_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] target_value;
  logic signed [SAMPLE_WIDTH-1:0] measured_value;

  modport source(output valid, output target_value, output measured_value, input ready);
  modport sink(input valid, input target_value, input measured_value, output ready);
endinterface

interface ppis_out_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] drive;
  logic                           clamped;
  logic                           integral_gated;

  modport source(output valid, output drive, output clamped, output integral_gated,
                 input ready);
  modport sink(input valid, input drive, input clamped, input integral_gated,
               output ready);
endinterface

interface ppis_cfg_if #(parameter int DATA_W = 24);
  logic                           valid;
  logic                           ready;
  logic [ppis_pkg::CfgIdxW-1:0]   index;
  logic [DATA_W-1:0]              data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

[hdl/ppis_cfg.sv]
// Configuration register file.
module ppis_cfg #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int DATA_W       = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [ppis_pkg::CfgIdxW-1:0]      wr_index,
  input  logic [DATA_W-1:0]                 wr_data,
  output ppis_pkg::gains_t                  gains,
  output logic [ppis_pkg::LimitW-1:0]       int_limit,
  output logic signed [SAMPLE_WIDTH-1:0]    drive_max,
  output logic signed [SAMPLE_WIDTH-1:0]    drive_min,
  output logic [SAMPLE_WIDTH:0]             sep_thr,
  output logic                              sep_en
);

  ppis_pkg::gains_t                  gains_r;
  logic [ppis_pkg::LimitW-1:0]       int_limit_r;
  logic signed [SAMPLE_WIDTH-1:0]    drive_max_r;
  logic signed [SAMPLE_WIDTH-1:0]    drive_min_r;
  logic [SAMPLE_WIDTH:0]             sep_thr_r;
  logic                              sep_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.p   <= ppis_pkg::GainPReset;
      gains_r.i   <= '0;
      gains_r.d   <= '0;
      int_limit_r <= ppis_pkg::IntLimitReset;
      drive_max_r <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      drive_min_r <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      sep_thr_r   <= '1;
      sep_en_r    <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        ppis_pkg::REG_GAIN_P:    gains_r.p   <= wr_data[ppis_pkg::GainW-1:0];
        ppis_pkg::REG_GAIN_I:    gains_r.i   <= wr_data[ppis_pkg::GainW-1:0];
        ppis_pkg::REG_GAIN_D:    gains_r.d   <= wr_data[ppis_pkg::GainW-1:0];
        ppis_pkg::REG_INT_LIMIT: int_limit_r <= wr_data[ppis_pkg::LimitW-1:0];
        ppis_pkg::REG_DRIVE_MAX: drive_max_r <= wr_data[SAMPLE_WIDTH-1:0];
        ppis_pkg::REG_DRIVE_MIN: drive_min_r <= wr_data[SAMPLE_WIDTH-1:0];
        ppis_pkg::REG_SEP_THR:   sep_thr_r   <= wr_data[SAMPLE_WIDTH:0];
        ppis_pkg::REG_SEP_EN:    sep_en_r    <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign gains     = gains_r;
  assign int_limit = int_limit_r;
  assign drive_max = drive_max_r;
  assign drive_min = drive_min_r;
  assign sep_thr   = sep_thr_r;
  assign sep_en    = sep_en_r;

endmodule

[hdl/ppis_front.sv]
// Front end: error, derivative difference, integral update and separation test.
`include "positional_pid_with_integral_separation_assert.svh"

module ppis_front #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ITEM_W       = 2 * SAMPLE_WIDTH + 3 + ppis_pkg::IntegW + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    target_value,
  input  logic signed [SAMPLE_WIDTH-1:0]    measured_value,
  input  logic [ppis_pkg::LimitW-1:0]       int_limit,
  input  logic [SAMPLE_WIDTH:0]             sep_thr,
  input  logic                              sep_en,
  output logic                              push_valid,
  input  logic                              push_ready,
  output logic [ITEM_W-1:0]                 push_data
);

  localparam int EW = SAMPLE_WIDTH + 1;
  localparam int IW = ((ppis_pkg::IntegW > EW) ? ppis_pkg::IntegW : EW) + 1;

  logic signed [EW-1:0]               err;
  logic [EW-1:0]                      mag;
  logic signed [EW:0]                 diff;
  logic                               gated;
  logic signed [IW-1:0]               isum;
  logic signed [IW-1:0]               lim;
  logic signed [IW-1:0]               iclamp;
  logic signed [ppis_pkg::IntegW-1:0] integ_nxt;
  logic signed [ppis_pkg::IntegW-1:0] integ_r;
  logic signed [EW-1:0]               last_err_r;
  logic                               fire;

  assign fire       = in_valid && push_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  assign err   = EW'(target_value) - EW'(measured_value);
  assign mag   = err[EW-1] ? EW'(-err) : EW'(err);
  assign gated = sep_en && (mag > sep_thr);
  assign diff  = (EW+1)'(err) - (EW+1)'(last_err_r);

  // integral accumulates even when its term is gated
  assign isum = IW'(integ_r) + IW'(err);
  assign lim  = $signed({{(IW-ppis_pkg::LimitW){1'b0}}, int_limit});

  always_comb begin
    if (isum > lim) begin
      iclamp = lim;
    end else if (isum < -lim) begin
      iclamp = -lim;
    end else begin
      iclamp = isum;
    end
  end

  assign integ_nxt = ppis_pkg::IntegW'(iclamp);
  assign push_data = {err, diff, integ_nxt, gated};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
    end else if (fire) begin
      integ_r    <= integ_nxt;
      last_err_r <= err;
    end
  end

  `PPIS_ASSERT_NEXT(a_last_err_tracks, fire, last_err_r == $past(err), "last error not updated")
  `PPIS_ASSERT_NEXT(a_integ_hold, !fire, $stable(integ_r), "integral moved without a beat")

endmodule

[hdl/ppis_fifo.sv]
// Small queue between the front end and the arithmetic back end.
`include "positional_pid_with_integral_separation_assert.svh"

module ppis_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            push;
  logic            pop;

  assign push_ready = (count_r != CntW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `PPIS_ASSERT(a_count_bound, count_r <= CntW'(DEPTH), "queue count above depth")
  `PPIS_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count lost a push")

endmodule

[hdl/ppis_back.sv]
// Back end: gain products, then sum, scaling, output clamp and output register.
`include "positional_pid_with_integral_separation_assert.svh"

module ppis_back #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8,
  parameter int ITEM_W         = 2 * SAMPLE_WIDTH + 3 + ppis_pkg::IntegW + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  logic [ITEM_W-1:0]                 pop_data,
  input  ppis_pkg::gains_t                  gains,
  input  logic signed [SAMPLE_WIDTH-1:0]    drive_max,
  input  logic signed [SAMPLE_WIDTH-1:0]    drive_min,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    drive,
  output logic                              clamped,
  output logic                              integral_gated
);

  localparam int EW   = SAMPLE_WIDTH + 1;
  localparam int DW   = SAMPLE_WIDTH + 2;
  localparam int GW   = ppis_pkg::GainW;
  localparam int NW   = ppis_pkg::IntegW;
  localparam int PW   = EW + GW;
  localparam int IPW  = NW + GW;
  localparam int DPW  = DW + GW;
  localparam int MAXW = (DPW > IPW) ? DPW : IPW;
  localparam int SUMW = MAXW + 2;

  logic signed [EW-1:0]   q_err;
  logic signed [DW-1:0]   q_diff;
  logic signed [NW-1:0]   q_integ;
  logic                   q_gated;

  logic signed [PW-1:0]   p_prod_r;
  logic signed [IPW-1:0]  i_prod_r;
  logic signed [DPW-1:0]  d_prod_r;
  logic                   gated_s1_r;
  logic                   s1_valid_r;
  logic                   s1_en;

  logic signed [SUMW-1:0] sum;
  logic signed [SUMW-1:0] y;
  logic                   over_hi;
  logic                   under_lo;

  logic                   out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] drive_r;
  logic                   clamped_r;
  logic                   gated_r;
  logic                   out_en;

  assign q_err   = $signed(pop_data[ITEM_W-1 -: EW]);
  assign q_diff  = $signed(pop_data[ITEM_W-EW-1 -: DW]);
  assign q_integ = $signed(pop_data[NW:1]);
  assign q_gated = pop_data[0];

  assign out_en    = !out_valid_r || out_ready;
  assign s1_en     = !s1_valid_r || out_en;
  assign pop_ready = s1_en;

  // stage 1: three gain products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && pop_valid) begin
      p_prod_r   <= $signed(gains.p) * q_err;
      if (q_gated) begin
        i_prod_r <= '0;
      end else begin
        i_prod_r <= $signed(gains.i) * q_integ;
      end
      d_prod_r   <= $signed(gains.d) * q_diff;
      gated_s1_r <= q_gated;
    end
  end

  // stage 2: sum, floor shift by the gain fraction, then clamp (max test wins)
  assign sum      = SUMW'(p_prod_r) + SUMW'(i_prod_r) + SUMW'(d_prod_r);
  assign y        = sum >>> GAIN_FRAC_BITS;
  assign over_hi  = (y > drive_max);
  assign under_lo = !over_hi && (y < drive_min);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      if (over_hi) begin
        drive_r <= drive_max;
      end else if (under_lo) begin
        drive_r <= drive_min;
      end else begin
        drive_r <= y[SAMPLE_WIDTH-1:0];
      end
      clamped_r <= over_hi || under_lo;
      gated_r   <= gated_s1_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign drive          = drive_r;
  assign clamped        = clamped_r;
  assign integral_gated = gated_r;

  `PPIS_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_en, s1_valid_r && $stable(p_prod_r), "stage 1 overwritten")
  `PPIS_ASSERT_NEXT(a_out_load, out_en && s1_valid_r, out_valid_r, "result dropped at output")

endmodule

[hdl/positional_pid_with_integral_separation.sv]
// Positional PID controller with integral separation, top level.
//
// Channels: in_ch takes one sample beat (target_value, measured_value);
// out_ch gives one result beat per sample (drive, clamped, integral_gated);
// cfg_ch writes register <index> with <data> and is always ready. Registers
// must be written only while no sample is in flight; the block does not
// enforce this. Throughput: one sample per cycle while out_ch does not stall.
// The front end updates the integral and last error in the accept cycle; a
// two-entry queue feeds a two-stage back end (gain multiplies, then
// sum/shift/clamp into the output register). An accepted sample passes through
// the queue, the stage 1 product registers and the output register to out_ch.
// Reset (rst_n low, synchronous): registers take their defaults, integral
// and last error clear, queue and pipeline empty.
// When out_ch stalls, the output register holds, the back end fills, then
// the queue fills and in_ch.ready drops; nothing is lost or repeated.
module positional_pid_with_integral_separation #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  ppis_in_if.sink    in_ch,
  ppis_out_if.source out_ch,
  ppis_cfg_if.sink   cfg_ch
);

  localparam int DATA_W = (ppis_pkg::LimitW > SAMPLE_WIDTH + 1) ?
                          ppis_pkg::LimitW : SAMPLE_WIDTH + 1;
  localparam int ITEM_W = 2 * SAMPLE_WIDTH + 3 + ppis_pkg::IntegW + 1;
  localparam int QDEPTH = 2;

  ppis_pkg::gains_t               gains;
  logic [ppis_pkg::LimitW-1:0]    int_limit;
  logic signed [SAMPLE_WIDTH-1:0] drive_max;
  logic signed [SAMPLE_WIDTH-1:0] drive_min;
  logic [SAMPLE_WIDTH:0]          sep_thr;
  logic                           sep_en;

  logic              q_push_valid;
  logic              q_push_ready;
  logic [ITEM_W-1:0] q_push_data;
  logic              q_pop_valid;
  logic              q_pop_ready;
  logic [ITEM_W-1:0] q_pop_data;

  assign cfg_ch.ready = 1'b1;

  ppis_cfg #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .DATA_W      (DATA_W)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data[DATA_W-1:0]),
    .gains    (gains),
    .int_limit(int_limit),
    .drive_max(drive_max),
    .drive_min(drive_min),
    .sep_thr  (sep_thr),
    .sep_en   (sep_en)
  );

  ppis_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ITEM_W      (ITEM_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .target_value  (in_ch.target_value),
    .measured_value(in_ch.measured_value),
    .int_limit     (int_limit),
    .sep_thr       (sep_thr),
    .sep_en        (sep_en),
    .push_valid    (q_push_valid),
    .push_ready    (q_push_ready),
    .push_data     (q_push_data)
  );

  ppis_fifo #(
    .W    (ITEM_W),
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_data (q_push_data),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data)
  );

  ppis_back #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .ITEM_W        (ITEM_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (q_pop_valid),
    .pop_ready     (q_pop_ready),
    .pop_data      (q_pop_data),
    .gains         (gains),
    .drive_max     (drive_max),
    .drive_min     (drive_min),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .drive         (out_ch.drive),
    .clamped       (out_ch.clamped),
    .integral_gated(out_ch.integral_gated)
  );

endmodule

[verif/ppis_drive_checker.sv]
// Scoreboard for the PID controller: mirrors the registers, predicts every drive beat, compares.
`timescale 1ns / 100ps
module ppis_drive_checker #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  ppis_in_if   in_mon,
  ppis_out_if  out_mon,
  ppis_cfg_if  cfg_mon,
  output int   bad_fields,
  output int   drives_due
);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] drive;
    logic                           clamped;
    logic                           integral_gated;
  } drive_beat_t;

  ppis_pkg::gains_t                   gains;
  logic [ppis_pkg::LimitW-1:0]        integ_lim;
  logic signed [SAMPLE_WIDTH-1:0]     drive_hi;
  logic signed [SAMPLE_WIDTH-1:0]     drive_lo;
  logic [SAMPLE_WIDTH:0]              sep_thr;
  logic                               sep_on;
  logic signed [ppis_pkg::IntegW-1:0] integ;
  logic signed [SAMPLE_WIDTH:0]       err_prev;
  drive_beat_t                        drive_due_q[$];
  int                                 mism = 0;

  // One controller step: updates integral and previous error, returns the drive beat.
  function automatic drive_beat_t compute_drive(input logic signed [SAMPLE_WIDTH-1:0] tgt,
                                                input logic signed [SAMPLE_WIDTH-1:0] meas);
    longint      err;
    longint      acc;
    longint      total;
    longint      y;
    drive_beat_t r;
    err = longint'(tgt) - longint'(meas);
    r.integral_gated = sep_on && ((err < 0 ? -err : err) > longint'(sep_thr));
    // integral keeps accumulating even when its term is gated off
    acc = longint'(integ) + err;
    if (acc > longint'(integ_lim)) acc = longint'(integ_lim);
    else if (acc < -longint'(integ_lim)) acc = -longint'(integ_lim);
    total = longint'($signed(gains.p)) * err
          + longint'($signed(gains.d)) * (err - longint'(err_prev));
    if (!r.integral_gated) total += longint'($signed(gains.i)) * acc;
    y = total >>> GAIN_FRAC_BITS;
    // max test first: with crossed limits it wins
    r.clamped = 1'b1;
    if (y > longint'(drive_hi)) y = longint'(drive_hi);
    else if (y < longint'(drive_lo)) y = longint'(drive_lo);
    else r.clamped = 1'b0;
    r.drive  = y[SAMPLE_WIDTH-1:0];
    integ    = acc[ppis_pkg::IntegW-1:0];
    err_prev = err[SAMPLE_WIDTH:0];
    return r;
  endfunction

  always @(posedge clk) begin
    drive_beat_t got;
    drive_beat_t want;
    if (!rst_n) begin
      gains.p   = ppis_pkg::GainPReset;
      gains.i   = '0;
      gains.d   = '0;
      integ_lim = ppis_pkg::IntLimitReset;
      drive_hi  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      drive_lo  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      sep_thr   = '1;
      sep_on    = 1'b0;
      integ     = '0;
      err_prev  = '0;
      drive_due_q.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got.drive          = out_mon.drive;
        got.clamped        = out_mon.clamped;
        got.integral_gated = out_mon.integral_gated;
        if (drive_due_q.size() == 0) begin
          $display("%0t ns: drive beat with none due, expected nothing, got drive %0d",
                   $time, got.drive);
          mism++;
        end else begin
          want = drive_due_q.pop_front();
          if (got.drive !== want.drive) begin
            $display("%0t ns: drive mismatch, expected %0d, got %0d",
                     $time, want.drive, got.drive);
            mism++;
          end
          if (got.clamped !== want.clamped) begin
            $display("%0t ns: clamped mismatch, expected %0b, got %0b",
                     $time, want.clamped, got.clamped);
            mism++;
          end
          if (got.integral_gated !== want.integral_gated) begin
            $display("%0t ns: integral_gated mismatch, expected %0b, got %0b",
                     $time, want.integral_gated, got.integral_gated);
            mism++;
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        drive_due_q.push_back(compute_drive(in_mon.target_value, in_mon.measured_value));
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        case (cfg_mon.index)
          ppis_pkg::REG_GAIN_P:    gains.p   = cfg_mon.data[ppis_pkg::GainW-1:0];
          ppis_pkg::REG_GAIN_I:    gains.i   = cfg_mon.data[ppis_pkg::GainW-1:0];
          ppis_pkg::REG_GAIN_D:    gains.d   = cfg_mon.data[ppis_pkg::GainW-1:0];
          ppis_pkg::REG_INT_LIMIT: integ_lim = cfg_mon.data[ppis_pkg::LimitW-1:0];
          ppis_pkg::REG_DRIVE_MAX: drive_hi  = cfg_mon.data[SAMPLE_WIDTH-1:0];
          ppis_pkg::REG_DRIVE_MIN: drive_lo  = cfg_mon.data[SAMPLE_WIDTH-1:0];
          ppis_pkg::REG_SEP_THR:   sep_thr   = cfg_mon.data[SAMPLE_WIDTH:0];
          ppis_pkg::REG_SEP_EN:    sep_on    = cfg_mon.data[0];
          default: ;
        endcase
      end
    end
    bad_fields <= mism;
    drives_due <= drive_due_q.size();
  end

endmodule

[verif/tb.sv]
// Testbench top for the PID controller: clock, reset, register setup, sample stimulus, verdict.
`timescale 1ns / 100ps
module tb;

  localparam int SW = 16;
  localparam int FB = 8;

  typedef enum int {RX_OPEN, RX_COIN, RX_SLUGGISH, RX_BLINK} rx_mode_t;

  logic clk;
  logic rst_n;
  int   bad_fields;
  int   drives_due;

  ppis_in_if  #(.SAMPLE_WIDTH(SW)) in_ch();
  ppis_out_if #(.SAMPLE_WIDTH(SW)) out_ch();
  ppis_cfg_if                      cfg_ch();

  positional_pid_with_integral_separation #(
    .SAMPLE_WIDTH  (SW),
    .GAIN_FRAC_BITS(FB)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  ppis_drive_checker #(
    .SAMPLE_WIDTH  (SW),
    .GAIN_FRAC_BITS(FB)
  ) i_drive_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_mon   (cfg_ch),
    .bad_fields(bad_fields),
    .drives_due(drives_due)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog, set far above the slowest stalled run
  initial begin
    #4_000_000;
    $display("** positional_pid_with_integral_separation: FAILED **");
    $finish;
  end

  // receiver backpressure: switches among open, coin-flip, sluggish and blinking modes
  initial begin
    rx_mode_t mode;
    int       left;
    mode = RX_OPEN;
    left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(16, 200);
      end
      left--;
      case (mode)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_COIN:     out_ch.ready <= $urandom_range(0, 1);
        RX_SLUGGISH: out_ch.ready <= ($urandom_range(0, 7) == 0);
        default:     out_ch.ready <= (left % 6 < 4);
      endcase
    end
  end

  // holds valid high after the beat; caller decides whether to drop it
  task automatic push_sample(input int tv, input int mv);
    in_ch.valid          <= 1'b1;
    in_ch.target_value   <= tv[SW-1:0];
    in_ch.measured_value <= mv[SW-1:0];
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (drives_due != 0) @(posedge clk);
  endtask

  // writes all eight registers; unused upper data bits carry junk
  task automatic program_ctrl(input logic [15:0] gp, input logic [15:0] gi,
                              input logic [15:0] gd, input logic [23:0] lim,
                              input logic [15:0] dmax, input logic [15:0] dmin,
                              input logic [16:0] thr, input logic sep);
    logic [23:0] vals [8];
    logic [23:0] junk;
    junk = $urandom;
    vals[ppis_pkg::REG_GAIN_P]    = {junk[23:16], gp};
    vals[ppis_pkg::REG_GAIN_I]    = {junk[15:8], gi};
    vals[ppis_pkg::REG_GAIN_D]    = {junk[7:0], gd};
    vals[ppis_pkg::REG_INT_LIMIT] = lim;
    vals[ppis_pkg::REG_DRIVE_MAX] = {junk[19:12], dmax};
    vals[ppis_pkg::REG_DRIVE_MIN] = {junk[11:4], dmin};
    vals[ppis_pkg::REG_SEP_THR]   = {junk[23:17], thr};
    vals[ppis_pkg::REG_SEP_EN]    = {junk[22:0], sep};
    for (int r = 0; r < 8; r++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= r[ppis_pkg::CfgIdxW-1:0];
      cfg_ch.data  <= vals[r];
      @(posedge clk);
      while (cfg_ch.ready !== 1'b1) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int rail_vals [4];
    int gp, gi, gd, lim, dmax, dmin, thr, sep, swap;
    int err_bias, spread, sent, burst, gap, roll, pick;
    int e, lo, hi, tv, mv;
    rail_vals = '{32767, -32768, 0, -1};
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.target_value   <= '0;
    in_ch.measured_value <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= ppis_pkg::REG_GAIN_P;
    cfg_ch.data          <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: unity P, no separation
    push_sample(0, 0);
    push_sample(32767, -32768);
    push_sample(-32768, 32767);
    push_sample(-1, 0);
    push_sample(12345, -2345);
    settle();
    // separation at and just above the threshold
    program_ctrl(256, 256, 256, 100, 32767, -32768, 10, 1'b1);
    push_sample(10, 0);
    push_sample(0, 11);
    push_sample(-32768, 32767);
    push_sample(5, 5);
    settle();
    // crossed output limits
    program_ctrl(256, 0, 0, 100, -100, 100, 17'h1FFFF, 1'b0);
    push_sample(-200, 0);
    push_sample(0, 0);
    push_sample(-100, 0);
    settle();
    // saturate the integral, then lower its limit
    program_ctrl(0, 256, 0, 1000, 32767, -32768, 17'h1FFFF, 1'b0);
    push_sample(500, 0);
    push_sample(500, 0);
    push_sample(500, 0);
    settle();
    program_ctrl(0, 256, 0, 10, 32767, -32768, 17'h1FFFF, 1'b0);
    push_sample(0, 0);
    push_sample(-3, 0);
    settle();
    program_ctrl(-32768, 32767, -32768, 24'hFFFFFF, 32767, -32768, 0, 1'b1);
    push_sample(32767, -32768);
    push_sample(-32768, 32767);
    push_sample(0, 0);

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      if (ph == 0) begin
        gp = 32767; gi = 32767; gd = 32767; lim = 24'hFFFFFF;
        dmax = 32767; dmin = -32768; thr = 17'h1FFFF; sep = 1;
      end else if (ph == 1) begin
        gp = -32768; gi = -32768; gd = -32768; lim = 0;
        dmax = -32768; dmin = 32767; thr = 0; sep = 1;
      end else begin
        gp = ($urandom_range(0, 2) == 0) ? $urandom : int'($urandom_range(0, 1024)) - 512;
        gi = ($urandom_range(0, 2) == 0) ? $urandom : int'($urandom_range(0, 1024)) - 512;
        gd = ($urandom_range(0, 2) == 0) ? $urandom : int'($urandom_range(0, 1024)) - 512;
        lim = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4000) : $urandom_range(0, 24'hFFFFFF);
        dmax = int'($urandom_range(0, 65535)) - 32768;
        dmin = int'($urandom_range(0, 65535)) - 32768;
        if (dmax < dmin && $urandom_range(0, 3) != 0) begin
          swap = dmax; dmax = dmin; dmin = swap;
        end
        if ($urandom_range(0, 3) == 0) begin
          dmax = 32767; dmin = -32768;
        end
        thr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4000) : $urandom_range(0, 17'h1FFFF);
        sep = $urandom_range(0, 1);
      end
      program_ctrl(gp, gi, gd, lim, dmax, dmin, thr, sep);
      err_bias = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 131070)) - 65535 : 0;
      spread   = 1 << $urandom_range(0, 12);
      sent     = 0;
      while (sent < 150) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < 150; k++) begin
          pick = $urandom_range(0, 9);
          if (pick < 3) begin
            tv = $urandom;
            mv = $urandom;
          end else if (pick < 9) begin
            // error near the phase bias, operands kept in range
            e = err_bias + int'($urandom_range(0, 2 * spread)) - spread;
            if (e > 65535) e = 65535;
            else if (e < -65535) e = -65535;
            lo = (e > 0) ? -32768 : -32768 - e;
            hi = (e > 0) ? 32767 - e : 32767;
            mv = lo + int'($urandom_range(0, hi - lo));
            tv = mv + e;
          end else begin
            tv = rail_vals[$urandom_range(0, 3)];
            mv = rail_vals[$urandom_range(0, 3)];
          end
          push_sample(tv, mv);
          sent++;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          settle();
        end else if (roll < 60) begin
          gap = $urandom_range(1, (roll < 10) ? 30 : 5);
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (bad_fields == 0 && drives_due == 0) begin
      $display("** positional_pid_with_integral_separation: PASSED **");
    end else begin
      $display("** positional_pid_with_integral_separation: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/ppis_pkg.sv
hdl/ppis_if.sv
hdl/ppis_cfg.sv
hdl/ppis_front.sv
hdl/ppis_fifo.sv
hdl/ppis_back.sv
hdl/positional_pid_with_integral_separation.sv
verif/ppis_drive_checker.sv
verif/tb.sv
